[hw/rtl/rsts_pkg.sv]
package rsts_pkg;

    // Head words of the tags, as they read in little-endian order.
    localparam logic [31:0] TAG_EEPR = 32'h5250_4545;
    localparam logic [31:0] TAG_SRAM = 32'h4D41_5253;
    localparam logic [31:0] TAG_FLAS = 32'h5341_4C46;
    localparam logic [31:0] TAG_SIIR = 32'h5249_4953;

    // Tails of the tags in the following word.
    localparam logic [23:0] TAIL_OM_  = 24'h5F_4D4F;
    localparam logic [31:0] TAIL_H1M_ = 32'h5F4D_3148;
    localparam logic [31:0] TAIL_TC_V = 32'h565F_4354;
    localparam logic [7:0]  TAIL_US   = 8'h5F;
    localparam logic [7:0]  TAIL_H    = 8'h48;

    typedef enum logic [1:0] {
        SAVE_NONE   = 2'd0,
        SAVE_SRAM   = 2'd1,
        SAVE_FLASH  = 2'd2,
        SAVE_EEPROM = 2'd3
    } save_type_t;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [1:0] save_type;
        logic       flash_large;
        logic       clock_found;
    } out_item_t;

    // Tag hits for one word pair.
    typedef struct packed {
        logic eeprom;
        logic sram;
        logic flash_large;
        logic flash_small;
        logic clock;
    } tag_hit_t;

endpackage

[hw/rtl/rsts_tag_match.sv]
module rsts_tag_match
    import rsts_pkg::*;
(
    input  logic [31:0] head,
    input  logic [31:0] tail,
    output tag_hit_t    hit
);

    // Each head word selects one tag; the tail decides whether it completes.
    always_comb begin
        hit = '0;
        hit.eeprom      = (head == TAG_EEPR) && (tail[23:0] == TAIL_OM_);
        hit.sram        = (head == TAG_SRAM) && (tail[7:0] == TAIL_US);
        hit.flash_large = (head == TAG_FLAS) && (tail == TAIL_H1M_);
        // Plain FLASH only counts when the 128 KiB form does not match.
        hit.flash_small = (head == TAG_FLAS) && (tail != TAIL_H1M_)
                          && (tail[7:0] == TAIL_H);
        hit.clock       = (head == TAG_SIIR) && (tail == TAIL_TC_V);
    end

endmodule

[hw/rtl/rom_save_type_scanner.sv]
// Channel  | Direction | Payload                                  | Handshake
// s_       | in        | word[31:0], last                         | s_valid / s_ready
// m_       | out       | save_type[1:0], flash_large, clock_found | m_valid / m_ready
//
// One word is taken per cycle while s_ready is high; the tag compare against
// the held word sits between the held-word register and the result register.
// A request with last set has its result in the output register in the next cycle.
// Reset (aresetn low, synchronous) clears the held-word valid flag, the scan state and m_valid.
// Only the output register stalls the input: s_ready is low while a result waits and m_ready is low.
module rom_save_type_scanner
    import rsts_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    logic [31:0] held_word_reg, held_word_next;
    logic        held_valid_reg, held_valid_next;
    save_type_t  found_type_reg, found_type_next;
    logic        found_large_reg, found_large_next;
    logic        found_clock_reg, found_clock_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_payload_reg, m_payload_next;

    tag_hit_t hit;
    logic     s_accept;

    rsts_tag_match u_match (
        .head (held_word_reg),
        .tail (s_payload.word),
        .hit  (hit)
    );

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Scan state and result register update.
    always_comb begin
        save_type_t type_upd;
        logic       large_upd;
        logic       clock_upd;

        type_upd  = found_type_reg;
        large_upd = found_large_reg;
        clock_upd = found_clock_reg;

        // The first save tag wins; the clock tag may appear anywhere.
        if (held_valid_reg && found_type_reg == SAVE_NONE) begin
            if (hit.eeprom) begin
                type_upd  = SAVE_EEPROM;
                large_upd = 1'b0;
            end else if (hit.sram) begin
                type_upd  = SAVE_SRAM;
                large_upd = 1'b0;
            end else if (hit.flash_large) begin
                type_upd  = SAVE_FLASH;
                large_upd = 1'b1;
            end else if (hit.flash_small) begin
                type_upd  = SAVE_FLASH;
                large_upd = 1'b0;
            end
        end
        if (held_valid_reg && hit.clock) begin
            clock_upd = 1'b1;
        end

        held_word_next   = held_word_reg;
        held_valid_next  = held_valid_reg;
        found_type_next  = found_type_reg;
        found_large_next = found_large_reg;
        found_clock_next = found_clock_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_payload_next   = m_payload_reg;

        if (s_accept) begin
            if (s_payload.last) begin
                // Publish the result and clear the scan for the next image.
                m_valid_next               = 1'b1;
                m_payload_next.save_type   = type_upd;
                m_payload_next.flash_large = (type_upd == SAVE_FLASH) && large_upd;
                m_payload_next.clock_found = clock_upd;
                held_word_next             = '0;
                held_valid_next            = 1'b0;
                found_type_next            = SAVE_NONE;
                found_large_next           = 1'b0;
                found_clock_next           = 1'b0;
            end else begin
                held_word_next   = s_payload.word;
                held_valid_next  = 1'b1;
                found_type_next  = type_upd;
                found_large_next = large_upd;
                found_clock_next = clock_upd;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg  <= 1'b0;
            found_type_reg  <= SAVE_NONE;
            found_large_reg <= 1'b0;
            found_clock_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            held_valid_reg  <= held_valid_next;
            found_type_reg  <= found_type_next;
            found_large_reg <= found_large_next;
            found_clock_reg <= found_clock_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        held_word_reg <= held_word_next;
        m_payload_reg <= m_payload_next;
    end

endmodule

[hw/rtl/rsts_checker.sv]
module rsts_checker
    import rsts_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_payload,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_payload
);

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("stalled result changed or dropped");

    // The image's final word always yields a result on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.last |=> m_valid)
        else $error("no result after final word");

    // Flash size is only reported for flash saves.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.save_type != SAVE_FLASH |-> !m_payload.flash_large)
        else $error("flash size set for a non-flash save type");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind rom_save_type_scanner rsts_checker u_rsts_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
